>>> rtl/cca_pkg.sv
// calendar clock advance: shared constants and the month-length lookup
// no dependencies; used by calendar_clock_advance_top
`default_nettype none

package cca_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int INC_W         = 32;
    localparam int SEC_W         = 22;
    localparam int WHOLE_W       = INC_W + 1 - FRACTION_BITS;
    localparam int OUT_W         = 64;

    // reciprocal constants for division of the whole seconds by 60 and 3600
    localparam logic [15:0] RECIP_60    = 16'd34953;
    localparam int          SHIFT_60    = 21;
    localparam logic [16:0] RECIP_3600  = 17'd74566;
    localparam int          SHIFT_3600  = 28;

    localparam logic [15:0] YEAR_MAX    = 16'hFFFF;
    localparam logic [8:0]  CYCLE_LAST  = 9'd399;

    localparam logic [15:0] RST_YEAR    = 16'd1;
    localparam logic [3:0]  RST_MONTH   = 4'd1;
    localparam logic [4:0]  RST_DAY     = 5'd1;
    localparam logic [4:0]  RST_HOUR    = 5'd6;
    localparam logic [5:0]  RST_MINUTE  = 6'd0;

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // days in a month; anything outside 1..12 reads as january
    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        unique case (month)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_clock_advance_top.sv
// calendar clock advance: input register, carry logic and result register
// depends on cca_pkg for constants and the month-length lookup
// a result word is loaded from the input register once the result register is free
// one word per cycle while the output is not stalled; the date and time carry
// chain is combinational between the input register and the result register
// both registers are parted by their own valid bits, so one input word is taken while a
// result waits; reset is synchronous, active low, and sets year 1, january 1, 06:00
`default_nettype none

module calendar_clock_advance_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // seconds_increment
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // year_now, month_now, day_now, hour_now, minute_now, second_now,
    // year_wrapped, zero pad
    output logic [63:0] o_m_tdata
);

    localparam int FB = cca_pkg::FRACTION_BITS;

    logic                        r_in_valid;
    logic [cca_pkg::INC_W-1:0]   r_inc;
    logic                        r_out_valid;
    logic [cca_pkg::OUT_W-1:0]   r_out;

    logic [15:0]               r_year;
    logic [8:0]                r_year_mod400;
    logic [3:0]                r_month;
    logic [4:0]                r_day;
    logic [4:0]                r_hour;
    logic [5:0]                r_minute;
    logic [cca_pkg::SEC_W-1:0] r_second;

    logic advance;

    logic [cca_pkg::INC_W:0]     sum;
    logic [cca_pkg::WHOLE_W-1:0] whole;
    logic [32:0]                 p60;
    logic [33:0]                 p3600;
    logic [10:0]                 q60;
    logic [4:0]                  q3600;
    logic [10:0]                 min_part;
    logic [16:0]                 sec_part;
    logic [6:0]                  min_sum;
    logic                        carry_hour;
    logic [5:0]                  hour_sum;
    logic                        carry_day;
    logic                        leap;
    logic [4:0]                  lim;

    logic [15:0]               n_year;
    logic [8:0]                n_year_mod400;
    logic [3:0]                n_month;
    logic [4:0]                n_day;
    logic [4:0]                n_hour;
    logic [5:0]                n_minute;
    logic [cca_pkg::SEC_W-1:0] n_second;
    logic                      n_wrapped;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_comb begin
        sum   = {1'b0, r_inc} + {{(cca_pkg::INC_W + 1 - cca_pkg::SEC_W){1'b0}}, r_second};
        whole = sum[cca_pkg::INC_W:FB];

        p60   = 33'(whole) * 33'(cca_pkg::RECIP_60);
        p3600 = 34'(whole) * 34'(cca_pkg::RECIP_3600);
        q60   = p60[cca_pkg::SHIFT_60 + 10:cca_pkg::SHIFT_60];
        q3600 = p3600[cca_pkg::SHIFT_3600 + 4:cca_pkg::SHIFT_3600];

        // whole minutes beyond the whole hours, and seconds beyond the minutes
        min_part = q60 - 11'(q3600) * 11'd60;
        sec_part = whole - 17'(q60) * 17'd60;

        n_second = {sec_part[cca_pkg::SEC_W-FB-1:0], sum[FB-1:0]};

        min_sum    = {1'b0, r_minute} + {1'b0, min_part[5:0]};
        carry_hour = (min_sum >= 7'd60);
        n_minute   = carry_hour ? 6'(min_sum - 7'd60) : min_sum[5:0];

        hour_sum  = {1'b0, r_hour} + {1'b0, q3600} + {5'd0, carry_hour};
        carry_day = (hour_sum >= 6'd24);
        n_hour    = carry_day ? 5'(hour_sum - 6'd24) : hour_sum[4:0];

        leap = (r_year[1:0] == 2'd0) &&
               !(r_year_mod400 == 9'd100 || r_year_mod400 == 9'd200 ||
                 r_year_mod400 == 9'd300);
        lim  = cca_pkg::month_length(r_month, leap);

        n_day         = r_day;
        n_month       = r_month;
        n_year        = r_year;
        n_year_mod400 = r_year_mod400;
        n_wrapped     = 1'b0;
        if (carry_day) begin
            if (r_day >= lim) begin
                n_day = 5'd1;
                if (r_month >= cca_pkg::MON_DEC) begin
                    n_month = 4'd1;
                    if (r_year == cca_pkg::YEAR_MAX) begin
                        n_year        = cca_pkg::RST_YEAR;
                        n_year_mod400 = 9'd1;
                        n_wrapped     = 1'b1;
                    end else begin
                        n_year        = r_year + 16'd1;
                        n_year_mod400 = (r_year_mod400 == cca_pkg::CYCLE_LAST) ? 9'd0
                                        : r_year_mod400 + 9'd1;
                    end
                end else begin
                    n_month = r_month + 4'd1;
                end
            end else begin
                n_day = r_day + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_year        <= cca_pkg::RST_YEAR;
            r_year_mod400 <= 9'd1;
            r_month       <= cca_pkg::RST_MONTH;
            r_day         <= cca_pkg::RST_DAY;
            r_hour        <= cca_pkg::RST_HOUR;
            r_minute      <= cca_pkg::RST_MINUTE;
            r_second      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_year        <= n_year;
                r_year_mod400 <= n_year_mod400;
                r_month       <= n_month;
                r_day         <= n_day;
                r_hour        <= n_hour;
                r_minute      <= n_minute;
                r_second      <= n_second;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_inc <= i_s_tdata;
        end
        if (advance) begin
            r_out <= {5'd0, n_wrapped, n_second, n_minute, n_hour, n_day, n_month, n_year};
        end
    end

    a_minute_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minute < 6'd60)
        else $error("minute out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour < 5'd24)
        else $error("hour out of range");

    a_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day >= 5'd1 && r_day <= lim && r_month >= 4'd1 && r_month <= cca_pkg::MON_DEC)
        else $error("date outside the calendar");

    a_wrap_to_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_wrapped |=> r_year == cca_pkg::RST_YEAR && r_month == 4'd1)
        else $error("year wrap did not land on january of year 1");

    a_result_follows_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid && r_out[15:0] == r_year)
        else $error("result word does not match the updated year");

endmodule

`default_nettype wire
